@@ rtl/core/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg
// Types, codes and constants shared by the paged bump allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int MAX_PAGES_DEF = 16;

    localparam int SIZE_W     = 16;
    localparam int CAP_W      = 13;
    localparam int FAIL_W     = 4;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int PAGE_OUT_W = 4;
    localparam int OFF_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET    = 2'd1;
    localparam logic [OP_W-1:0] OP_RECREATE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_PAGE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;

    localparam logic [CAP_W-1:0]  CAP_RESET   = 13'd4056;
    localparam logic [FAIL_W-1:0] LIMIT_RESET = 4'd4;
    localparam logic [FAIL_W-1:0] FAIL_MAX    = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [FAIL_W-1:0] fail;
        logic [CAP_W-1:0]  used;
    } t_page_ent;

    typedef struct packed {
        logic we;
        logic clear;
    } t_mem_ctl;

    typedef struct packed {
        logic [CAP_W-1:0]  capacity;
        logic [FAIL_W-1:0] limit;
    } t_cfg;

endpackage

@@ rtl/core/pba_if.sv @@
// ----------------------------------------------------------------------------
// pba_if
// Handshake channels of the allocator: request items, result items, config.
// ----------------------------------------------------------------------------
interface pba_item_if import pba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [SIZE_W-1:0] request_size;

    modport source (output valid, output opcode, output request_size, input ready);
    modport sink   (input valid, input opcode, input request_size, output ready);
endinterface

interface pba_res_if import pba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STAT_W-1:0]     status;
    logic [PAGE_OUT_W-1:0] page_index;
    logic [OFF_W-1:0]      byte_offset;

    modport source (output valid, output status, output page_index, output byte_offset,
                    input ready);
    modport sink   (input valid, input status, input page_index, input byte_offset,
                    output ready);
endinterface

interface pba_cfg_if import pba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/pba_page_mem.sv @@
// ----------------------------------------------------------------------------
// pba_page_mem
// Page table RAM: fill mark and fail count per page, registered read,
// per-entry valid bits so that a clear takes effect at once.
// ----------------------------------------------------------------------------
module pba_page_mem import pba_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_mem_ctl        i_ctl,
    input  logic [PG_W-1:0] i_waddr,
    input  t_page_ent       i_wdata,
    input  logic [PG_W-1:0] i_raddr,
    output t_page_ent       o_rdata
);

    t_page_ent              r_mem [MAX_PAGES];
    logic [MAX_PAGES-1:0]   r_valid;
    t_page_ent              r_rdata;
    logic                   r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

@@ rtl/core/pba_scan_ctrl.sv @@
// ----------------------------------------------------------------------------
// pba_scan_ctrl
// Request sequencer: page scan over the page RAM, append, result register.
// ----------------------------------------------------------------------------
module pba_scan_ctrl import pba_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    parameter int CNT_W     = $clog2(MAX_PAGES + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    pba_item_if.sink        i_item,
    pba_res_if.source       o_res,
    output t_mem_ctl        o_mem_ctl,
    output logic [PG_W-1:0] o_waddr,
    output t_page_ent       o_wdata,
    output logic [PG_W-1:0] o_raddr,
    input  t_page_ent       i_rdata
);

    localparam logic [CNT_W-1:0] PAGES_MAX = CNT_W'(MAX_PAGES);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_pg, n_pg;
    logic [CNT_W-1:0]      r_cur, n_cur;
    logic [CNT_W-1:0]      r_pages, n_pages;
    logic                  r_chain, n_chain;
    logic [CAP_W-1:0]      r_size, n_size;
    logic [STAT_W-1:0]     r_stat, n_stat;
    logic [PAGE_OUT_W-1:0] r_page, n_page;
    logic [OFF_W-1:0]      r_off, n_off;
    logic                  r_ovalid, n_ovalid;
    logic [STAT_W-1:0]     r_ostat, n_ostat;
    logic [PAGE_OUT_W-1:0] r_opage, n_opage;
    logic [OFF_W-1:0]      r_ooff, n_ooff;

    logic                  accept;
    logic [CAP_W-1:0]      room;
    logic                  fit;
    logic [FAIL_W-1:0]     fail_inc;
    logic [CNT_W-1:0]      pg_next;

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;

    assign o_res.valid       = r_ovalid;
    assign o_res.status      = r_ostat;
    assign o_res.page_index  = r_opage;
    assign o_res.byte_offset = r_ooff;

    assign room     = (i_rdata.used >= i_cfg.capacity) ? '0 : i_cfg.capacity - i_rdata.used;
    assign fit      = (room >= r_size);
    assign fail_inc = (i_rdata.fail == FAIL_MAX) ? i_rdata.fail : i_rdata.fail + 1'b1;
    assign pg_next  = CNT_W'(r_pg + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_pages  <= CNT_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_pages  <= n_pages;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pg    <= n_pg;
        r_chain <= n_chain;
        r_size  <= n_size;
        r_stat  <= n_stat;
        r_page  <= n_page;
        r_off   <= n_off;
        r_ostat <= n_ostat;
        r_opage <= n_opage;
        r_ooff  <= n_ooff;
    end

    always_comb begin
        n_state   = r_state;
        n_pg      = r_pg;
        n_cur     = r_cur;
        n_pages   = r_pages;
        n_chain   = r_chain;
        n_size    = r_size;
        n_stat    = r_stat;
        n_page    = r_page;
        n_off     = r_off;
        n_ovalid  = r_ovalid && !o_res.ready;
        n_ostat   = r_ostat;
        n_opage   = r_opage;
        n_ooff    = r_ooff;
        o_mem_ctl = '0;
        o_waddr   = r_pg[PG_W-1:0];
        o_wdata   = i_rdata;
        o_raddr   = r_cur[PG_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_stat  = STAT_OK;
                    n_page  = '0;
                    n_off   = '0;
                    n_state = ST_DONE;
                    case (i_item.opcode)
                        OP_RESET: begin
                            o_mem_ctl.clear = 1'b1;
                            n_cur           = '0;
                        end
                        OP_RECREATE: begin
                            o_mem_ctl.clear = 1'b1;
                            n_cur           = '0;
                            n_pages         = CNT_W'(1);
                        end
                        OP_ALLOC: begin
                            if (i_item.request_size > SIZE_W'(i_cfg.capacity)) begin
                                n_stat = STAT_TOO_LARGE;
                            end else begin
                                n_size  = i_item.request_size[CAP_W-1:0];
                                n_pg    = r_cur;
                                n_chain = 1'b1;
                                n_state = (r_cur < r_pages) ? ST_SCAN : ST_APPEND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                o_mem_ctl.we = 1'b1;
                o_waddr      = r_pg[PG_W-1:0];
                if (fit) begin
                    o_wdata.fail = i_rdata.fail;
                    o_wdata.used = i_rdata.used + r_size;
                    n_stat       = STAT_OK;
                    n_page       = PAGE_OUT_W'(r_pg);
                    n_off        = i_rdata.used[OFF_W-1:0];
                    n_state      = ST_DONE;
                end else begin
                    o_wdata.fail = fail_inc;
                    o_wdata.used = i_rdata.used;
                    if (r_chain && (fail_inc > i_cfg.limit)) begin
                        n_cur = pg_next;
                    end else begin
                        n_chain = 1'b0;
                    end
                    n_pg    = pg_next;
                    o_raddr = pg_next[PG_W-1:0];
                    n_state = (pg_next < r_pages) ? ST_SCAN : ST_APPEND;
                end
            end

            ST_APPEND: begin
                n_page  = '0;
                n_off   = '0;
                n_state = ST_DONE;
                if (r_pages < PAGES_MAX) begin
                    o_mem_ctl.we = 1'b1;
                    o_waddr      = r_pages[PG_W-1:0];
                    o_wdata.fail = '0;
                    o_wdata.used = r_size;
                    n_pages      = CNT_W'(r_pages + 1'b1);
                    n_stat       = STAT_OK;
                    n_page       = PAGE_OUT_W'(r_pages);
                end else begin
                    n_stat = STAT_NO_PAGE;
                end
            end

            ST_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_stat;
                    n_opage  = r_page;
                    n_ooff   = r_off;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/paged_bump_allocator_top.sv @@
// ----------------------------------------------------------------------------
// paged_bump_allocator_top
// Bump allocator over a chain of equal-sized pages.
//
// Channels: i_item carries requests (opcode, request_size), o_res returns one
// result item per request (status, page_index, byte_offset), i_cfg writes
// page_capacity (index 0) and fail_limit (index 1). i_cfg is always ready; the
// user must write it only while the block is idle (not enforced by the block).
// One request is in flight at a time. An allocate reads the page RAM from the
// current page on, one page per cycle, tries to append a page if none fits,
// and then loads the result register. Reset, recreate, unused opcodes and
// too-large requests skip the scan and go straight to the result stage.
// A new request is taken as soon as the previous one has reached the result
// stage; if the receiver stalls, the finished result waits in the sequencer
// until the output register frees, and the channel holds its payload.
// Reset clears all pages at once via valid bits: no clearing pass, one page
// exists, current page is zero, registers return to 4056 and 4.
// ----------------------------------------------------------------------------
module paged_bump_allocator_top import pba_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pba_item_if.sink  i_item,
    pba_res_if.source o_res,
    pba_cfg_if.sink   i_cfg
);

    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);

    t_cfg            r_cfg;
    t_mem_ctl        mem_ctl;
    logic [PG_W-1:0] mem_waddr;
    logic [PG_W-1:0] mem_raddr;
    t_page_ent       mem_wdata;
    t_page_ent       mem_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity <= CAP_RESET;
            r_cfg.limit    <= LIMIT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_CAPACITY: r_cfg.capacity <= i_cfg.data[CAP_W-1:0];
                CFG_LIMIT:    r_cfg.limit    <= i_cfg.data[FAIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pba_scan_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .PG_W      (PG_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_item    (i_item),
        .o_res     (o_res),
        .o_mem_ctl (mem_ctl),
        .o_waddr   (mem_waddr),
        .o_wdata   (mem_wdata),
        .o_raddr   (mem_raddr),
        .i_rdata   (mem_rdata)
    );

    pba_page_mem #(
        .MAX_PAGES (MAX_PAGES),
        .PG_W      (PG_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != STAT_OK)) |->
            ((o_res.page_index == '0) && (o_res.byte_offset == '0)))
        else $error("error result carries a nonzero page or offset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("second item accepted while one is in flight");

    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && (i_item.opcode != OP_ALLOC) && !o_res.valid)
            |-> ##2 o_res.valid)
        else $error("non-allocate item did not finish in two cycles");

endmodule

@@ tb/sv/paged_bump_allocator_top_test.sv @@
// ----------------------------------------------------------------------------
// paged_bump_allocator_top_test
// Self-checking bench for the paged bump allocator. A queue-fed driver offers
// requests, a monitor checks each result against an in-bench model of the page
// chain, fill marks and fail counters. Config changes only while drained.
// ----------------------------------------------------------------------------
module paged_bump_allocator_top_test;
    import pba_pkg::*;

    localparam int PAGES       = MAX_PAGES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = PAGES + 8;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [PAGE_OUT_W-1:0] page;
        logic [OFF_W-1:0]      offset;
    } t_alloc_result;

    logic i_clk;
    logic i_rst_n;

    pba_item_if item_if ();
    pba_res_if  res_if ();
    pba_cfg_if  cfg_if ();

    paged_bump_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // allocator model state
    int fill_mark [PAGES];
    int miss_cnt  [PAGES];
    int page_count = 1;
    int scan_start;
    int cap_reg;
    int limit_reg;

    t_req          request_q[$];
    t_alloc_result alloc_results_q[$];

    int  queued_cnt;
    int  accepted_cnt;
    int  result_cnt;
    int  err_cnt;
    int  cycle_cnt;
    int  grant_cnt;
    int  large_cnt;
    int  nopage_cnt;
    int  send_gap;
    int  hold_gap;
    bit  send_idle;
    bit  recv_idle;
    logic long_hold;

    function automatic void clear_pages();
        for (int i = 0; i < PAGES; i++) begin
            fill_mark[i] = 0;
            miss_cnt[i]  = 0;
        end
        scan_start = 0;
    endfunction

    function automatic t_alloc_result bump_alloc(logic [OP_W-1:0] op, logic [SIZE_W-1:0] req);
        t_alloc_result r;
        int size;
        int room;
        int pg;
        bit done;
        r    = '0;
        size = req;
        done = 1'b0;
        case (op)
            OP_RESET: begin
                clear_pages();
            end
            OP_RECREATE: begin
                clear_pages();
                page_count = 1;
            end
            OP_ALLOC: begin
                if (size > cap_reg) begin
                    r.status = STAT_TOO_LARGE;
                    large_cnt++;
                end else begin
                    for (pg = scan_start; pg < page_count && pg < PAGES && !done; pg++) begin
                        room = (fill_mark[pg] >= cap_reg) ? 0 : cap_reg - fill_mark[pg];
                        if (room >= size) begin
                            r.page   = PAGE_OUT_W'(pg);
                            r.offset = OFF_W'(fill_mark[pg]);
                            fill_mark[pg] += size;
                            done = 1'b1;
                        end else begin
                            if (miss_cnt[pg] < FAIL_MAX)
                                miss_cnt[pg]++;
                            if (scan_start < PAGES && miss_cnt[scan_start] > limit_reg)
                                scan_start = pg + 1;
                        end
                    end
                    if (!done) begin
                        if (page_count < PAGES) begin
                            fill_mark[page_count] = size;
                            miss_cnt[page_count]  = 0;
                            r.page = PAGE_OUT_W'(page_count);
                            page_count++;
                        end else begin
                            r.status = STAT_NO_PAGE;
                            nopage_cnt++;
                        end
                    end
                    if (r.status == STAT_OK)
                        grant_cnt++;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic int sender_gap();
        return send_idle ? $urandom_range(0, 3) : 0;
    endfunction

    function automatic int receiver_gap();
        return recv_idle ? $urandom_range(0, 3) : 0;
    endfunction

    task automatic flag(string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s", msg);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_req nxt;
        bit   free;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            free = !item_if.valid;
            if (item_if.valid && item_if.ready) begin
                alloc_results_q.push_back(bump_alloc(item_if.opcode, item_if.request_size));
                accepted_cnt++;
                free     = 1'b1;
                send_gap = sender_gap();
            end
            if (free) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_if.valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    nxt = request_q.pop_front();
                    item_if.valid        <= 1'b1;
                    item_if.opcode       <= nxt.op;
                    item_if.request_size <= nxt.size;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                result_cnt++;
                if (alloc_results_q.size() == 0) begin
                    flag($sformatf("unexpected result %0d: status %0d page %0d offset %0d",
                                   result_cnt, res_if.status, res_if.page_index,
                                   res_if.byte_offset));
                end else begin
                    want = alloc_results_q.pop_front();
                    if (res_if.status !== want.status || res_if.page_index !== want.page ||
                        res_if.byte_offset !== want.offset)
                        flag($sformatf({"mismatch on result %0d: expected status %0d page %0d",
                                        " offset %0d, got status %0d page %0d offset %0d"},
                                       result_cnt, want.status, want.page, want.offset,
                                       res_if.status, res_if.page_index, res_if.byte_offset));
                end
                hold_gap = receiver_gap();
            end
            if (long_hold || hold_gap > 0) begin
                res_if.ready <= 1'b0;
                if (hold_gap > 0)
                    hold_gap--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    initial begin
        long_hold = 1'b0;
        while (accepted_cnt < 400)
            @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("paged_bump_allocator_top_test: done, errors");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic queue_req(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size);
        t_req r;
        r.op   = op;
        r.size = size;
        queued_cnt++;
        request_q.push_back(r);
    endtask

    function automatic t_req random_req(int cap);
        t_req r;
        int   pick;
        int   part;
        pick   = $urandom_range(0, 99);
        part   = (cap >= 8) ? cap / 8 : cap;
        r.op   = OP_ALLOC;
        r.size = SIZE_W'($urandom_range(0, 65535));
        if (pick < 45)
            r.size = SIZE_W'($urandom_range(0, part));
        else if (pick < 70)
            r.size = SIZE_W'($urandom_range(0, cap));
        else if (pick < 76)
            r.size = SIZE_W'(cap);
        else if (pick < 80)
            r.size = '0;
        else if (pick < 90)
            r.size = SIZE_W'($urandom_range(cap + 1, 65535));
        else if (pick < 94)
            r.op = OP_RESET;
        else if (pick < 97)
            r.op = OP_RECREATE;
        else
            r.op = OP_SPARE;
        return r;
    endfunction

    task automatic drain();
        while (queued_cnt != accepted_cnt || alloc_results_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready));
        if (idx == CFG_CAPACITY)
            cap_reg = val;
        else if (idx == CFG_LIMIT)
            limit_reg = val[FAIL_W-1:0];
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(int cap, int lim, int n, int ph);
        t_req r;
        drain();
        write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
        send_idle = (ph == 1) ? 1'b0 : (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1));
        recv_idle = (ph == 1) ? 1'b0 : (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1));
        repeat (n) begin
            r = random_req(cap);
            queue_req(r.op, r.size);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_CAPACITY;
        cfg_if.data  = '0;
        queued_cnt   = 0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        cap_reg      = CAP_RESET;
        limit_reg    = LIMIT_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: boundaries, too large, unused opcode, reset, recreate
        queue_req(OP_ALLOC, 16'd0);
        queue_req(OP_ALLOC, 16'd4056);
        queue_req(OP_ALLOC, 16'd4057);
        queue_req(OP_ALLOC, 16'hFFFF);
        queue_req(OP_ALLOC, 16'd1);
        queue_req(OP_SPARE, 16'hFFFF);
        queue_req(OP_RESET, 16'h5A5A);
        queue_req(OP_RECREATE, 16'hA5A5);

        // tiny pages, skip at once: fill all pages, hit the page limit,
        // then scan with current already past the last page
        drain();
        write_reg(CFG_CAPACITY, 13'd8);
        write_reg(CFG_LIMIT, 13'd0);
        queue_req(OP_RECREATE, 16'd0);
        repeat (PAGES) queue_req(OP_ALLOC, 16'd8);
        queue_req(OP_ALLOC, 16'd8);
        queue_req(OP_ALLOC, 16'd0);
        queue_req(OP_RESET, 16'd0);
        queue_req(OP_ALLOC, 16'd3);
        queue_req(OP_RECREATE, 16'd0);

        run_phase(4096, 14, 150, 0);
        run_phase(1, 0, 150, 1);
        run_phase(64, 15, 150, 2);
        run_phase(6000, 4, 150, 3);
        run_phase(int'(CAP_RESET), int'(LIMIT_RESET), 150, 4);
        for (int ph = 5; ph < 8; ph++)
            run_phase($urandom_range(1, 4096), $urandom_range(0, 15), 150, ph);

        drain();
        $display("covered %0d requests and %0d results over several capacity/limit settings",
                 accepted_cnt, result_cnt);
        $display("grants %0d, too large %0d, no page left %0d, mismatches %0d",
                 grant_cnt, large_cnt, nopage_cnt, err_cnt);
        if (err_cnt == 0)
            $display("paged_bump_allocator_top_test: done, clean");
        else
            $display("paged_bump_allocator_top_test: done, errors");
        $finish;
    end

endmodule
